// ===== rtl/core/mpss_pkg.sv =====
// Package for the MQTT packet stream splitter.
// Holds opcodes, parser constants, state and route enums, and controller/datapath structs.
// No dependencies.
package mpss_pkg;

  // input opcodes
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_RD_CTRL = 2'd1;
  localparam logic [1:0] OP_RD_PUB  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // fixed header
  localparam logic [3:0] PUBLISH_TYPE = 4'd3;
  localparam int         REM_W        = 28;
  localparam logic [1:0] LEN_LAST_IDX = 2'd3;

  // field widths
  localparam int COUNT_W = 7;
  localparam int AVAIL_W = 9;

  typedef enum logic [1:0] {
    ROUTE_PENDING = 2'd0,
    ROUTE_CTRL    = 2'd1,
    ROUTE_PUB     = 2'd2
  } route_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic rx_write;     // apply received byte
    logic restart;      // clear positions and parser
    logic burst_start;  // commit a read, load burst counters
    logic load_single;  // load the one-beat result
    logic issue;        // memory read of next byte
    logic move;         // memory data into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic read_ok;      // request count valid and available
    logic out_free;     // output register can take a beat
    logic rvalid;       // memory data register holds a byte
    logic rlast;        // that byte is the last of the burst
    logic left_nz;      // bytes still to be issued
  } sts_t;

endpackage

// ===== rtl/core/mpss_ctrl.sv =====
// Controller state machine of the MQTT packet stream splitter.
// Decodes accepted beats and sequences read bursts; uses mpss_pkg.
module mpss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [1:0]      opcode,
  output logic            in_tready,
  input  mpss_pkg::sts_t  sts,
  output mpss_pkg::cmd_t  cmd
);

  mpss_pkg::state_t state_r;
  mpss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic fire;
    logic move;
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    fire      = 1'b0;
    move      = 1'b0;
    case (state_r)
      mpss_pkg::ST_IDLE: begin
        in_tready = sts.out_free;
        fire      = in_tvalid && sts.out_free;
        if (fire) begin
          case (opcode)
            mpss_pkg::OP_RX: begin
              cmd.rx_write    = 1'b1;
              cmd.load_single = 1'b1;
            end
            mpss_pkg::OP_RESTART: begin
              cmd.restart     = 1'b1;
              cmd.load_single = 1'b1;
            end
            default: begin
              if (sts.read_ok) begin
                cmd.burst_start = 1'b1;
                state_nxt       = mpss_pkg::ST_BURST;
              end else begin
                cmd.load_single = 1'b1;
              end
            end
          endcase
        end
      end
      mpss_pkg::ST_BURST: begin
        move      = sts.rvalid && sts.out_free;
        cmd.move  = move;
        cmd.issue = sts.left_nz && (!sts.rvalid || move);
        if (move && sts.rlast) begin
          state_nxt = mpss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mpss_dp.sv =====
// Datapath of the MQTT packet stream splitter: both stores, their positions,
// the fixed-header parser, the read pipeline and the output register. Uses mpss_pkg.
module mpss_dp #(
  parameter int STORE_DEPTH = 256,
  parameter int MAX_READ    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    rx_byte,
  input  logic [mpss_pkg::COUNT_W-1:0]  read_count,
  input  logic                          out_tready,
  input  mpss_pkg::cmd_t                cmd,
  output mpss_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic [7:0]                    out_read_data,
  output logic                          out_read_valid,
  output logic                          out_last,
  output logic                          out_dropped,
  output logic [mpss_pkg::AVAIL_W-1:0]  out_ctrl_avail,
  output logic [mpss_pkg::AVAIL_W-1:0]  out_pub_avail,
  output logic                          out_idle
);

  localparam int AW = $clog2(STORE_DEPTH + 1);
  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW = $clog2(MAX_READ + 1);
  localparam int CW = (AW > mpss_pkg::COUNT_W) ? AW : mpss_pkg::COUNT_W;
  localparam int EW = (AW > mpss_pkg::AVAIL_W) ? AW : mpss_pkg::AVAIL_W;
  localparam logic [AW-1:0] DEPTH_A = AW'(STORE_DEPTH);
  localparam logic [mpss_pkg::COUNT_W-1:0] MAX_C = mpss_pkg::COUNT_W'(MAX_READ);

  logic [7:0] ctrl_mem_r [STORE_DEPTH];
  logic [7:0] pub_mem_r  [STORE_DEPTH];

  logic [AW-1:0] ctrl_wr_r, ctrl_wr_nxt, ctrl_rd_r, ctrl_rd_nxt;
  logic [AW-1:0] pub_wr_r,  pub_wr_nxt,  pub_rd_r,  pub_rd_nxt;

  mpss_pkg::route_t            route_r, route_nxt;
  logic                        in_len_r, in_len_nxt;
  logic [mpss_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [1:0]                  lidx_r, lidx_nxt;

  logic [IW-1:0] addr_r;
  logic [LW-1:0] left_r;
  logic          sel_pub_r;
  logic          rvalid_r, rlast_r;
  logic [7:0]    ctrl_q_r, pub_q_r;

  logic          out_valid_r;
  logic [7:0]    data_r;
  logic          rvld_r, last_r, drop_r, idle_r;
  logic [mpss_pkg::AVAIL_W-1:0] cav_r, pav_r;

  // store put decode
  logic          c_empty, p_empty, c_full, p_full, c_we, p_we, tgt_pub, drop_c;
  logic [AW-1:0] c_base, p_base;
  logic [mpss_pkg::REM_W-1:0] len_part, rem_or;
  logic [AW-1:0] sel_avail, sel_rd;
  logic          read_ok;
  logic          out_free;

  assign c_empty = (ctrl_rd_r == ctrl_wr_r);
  assign p_empty = (pub_rd_r == pub_wr_r);
  assign c_base  = c_empty ? '0 : ctrl_wr_r;
  assign p_base  = p_empty ? '0 : pub_wr_r;
  assign c_full  = (c_base == DEPTH_A);
  assign p_full  = (p_base == DEPTH_A);

  assign tgt_pub = (route_r == mpss_pkg::ROUTE_PENDING) ?
                   (rx_byte[7:4] == mpss_pkg::PUBLISH_TYPE) :
                   (route_r == mpss_pkg::ROUTE_PUB);
  assign c_we    = cmd.rx_write && !tgt_pub && !c_full;
  assign p_we    = cmd.rx_write && tgt_pub && !p_full;
  assign drop_c  = cmd.rx_write && (tgt_pub ? p_full : c_full);

  // next 7-bit group of the remaining length
  always_comb begin
    case (lidx_r)
      2'd0:    len_part = mpss_pkg::REM_W'(rx_byte[6:0]);
      2'd1:    len_part = mpss_pkg::REM_W'(rx_byte[6:0]) << 7;
      2'd2:    len_part = mpss_pkg::REM_W'(rx_byte[6:0]) << 14;
      default: len_part = mpss_pkg::REM_W'(rx_byte[6:0]) << 21;
    endcase
  end
  assign rem_or = rem_r | len_part;

  // read request check
  assign sel_avail = (opcode == mpss_pkg::OP_RD_PUB) ? (pub_wr_r - pub_rd_r)
                                                     : (ctrl_wr_r - ctrl_rd_r);
  assign sel_rd    = (opcode == mpss_pkg::OP_RD_PUB) ? pub_rd_r : ctrl_rd_r;
  assign read_ok   = (read_count != '0) && (read_count <= MAX_C) &&
                     (CW'(sel_avail) >= CW'(read_count));

  assign out_free = !out_valid_r || out_tready;

  assign sts.read_ok  = read_ok;
  assign sts.out_free = out_free;
  assign sts.rvalid   = rvalid_r;
  assign sts.rlast    = rlast_r;
  assign sts.left_nz  = (left_r != '0);

  // positions and parser next state
  always_comb begin
    ctrl_wr_nxt = ctrl_wr_r;
    ctrl_rd_nxt = ctrl_rd_r;
    pub_wr_nxt  = pub_wr_r;
    pub_rd_nxt  = pub_rd_r;
    route_nxt   = route_r;
    in_len_nxt  = in_len_r;
    rem_nxt     = rem_r;
    lidx_nxt    = lidx_r;
    if (cmd.restart) begin
      ctrl_wr_nxt = '0;
      ctrl_rd_nxt = '0;
      pub_wr_nxt  = '0;
      pub_rd_nxt  = '0;
      route_nxt   = mpss_pkg::ROUTE_PENDING;
      in_len_nxt  = 1'b0;
      rem_nxt     = '0;
      lidx_nxt    = '0;
    end else if (cmd.rx_write) begin
      // a put to an empty store rewinds it first
      if (tgt_pub) begin
        pub_rd_nxt = p_empty ? '0 : pub_rd_r;
        pub_wr_nxt = p_full ? p_base : p_base + AW'(1);
      end else begin
        ctrl_rd_nxt = c_empty ? '0 : ctrl_rd_r;
        ctrl_wr_nxt = c_full ? c_base : c_base + AW'(1);
      end
      if (route_r == mpss_pkg::ROUTE_PENDING) begin
        route_nxt  = tgt_pub ? mpss_pkg::ROUTE_PUB : mpss_pkg::ROUTE_CTRL;
        in_len_nxt = 1'b1;
        rem_nxt    = '0;
        lidx_nxt   = '0;
      end else if (in_len_r) begin
        rem_nxt = rem_or;
        // fourth length byte closes the field regardless of bit 7
        if (!rx_byte[7] || lidx_r == mpss_pkg::LEN_LAST_IDX) begin
          in_len_nxt = 1'b0;
          lidx_nxt   = '0;
          if (rem_or == '0) route_nxt = mpss_pkg::ROUTE_PENDING;
        end else begin
          lidx_nxt = lidx_r + 2'd1;
        end
      end else begin
        if (rem_r > mpss_pkg::REM_W'(1)) begin
          rem_nxt = rem_r - mpss_pkg::REM_W'(1);
        end else begin
          rem_nxt   = '0;
          route_nxt = mpss_pkg::ROUTE_PENDING;
        end
      end
    end else if (cmd.burst_start) begin
      // consume the whole burst up front; results report post-step counts
      if (opcode == mpss_pkg::OP_RD_PUB) begin
        pub_rd_nxt = pub_rd_r + AW'(read_count);
      end else begin
        ctrl_rd_nxt = ctrl_rd_r + AW'(read_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_wr_r <= '0;
      ctrl_rd_r <= '0;
      pub_wr_r  <= '0;
      pub_rd_r  <= '0;
      route_r   <= mpss_pkg::ROUTE_PENDING;
      in_len_r  <= 1'b0;
      rem_r     <= '0;
      lidx_r    <= '0;
      left_r    <= '0;
      rvalid_r  <= 1'b0;
      rlast_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_wr_r <= ctrl_wr_nxt;
      ctrl_rd_r <= ctrl_rd_nxt;
      pub_wr_r  <= pub_wr_nxt;
      pub_rd_r  <= pub_rd_nxt;
      route_r   <= route_nxt;
      in_len_r  <= in_len_nxt;
      rem_r     <= rem_nxt;
      lidx_r    <= lidx_nxt;
      if (cmd.burst_start) begin
        left_r <= LW'(read_count);
      end else if (cmd.issue) begin
        left_r <= left_r - LW'(1);
      end
      if (cmd.issue) begin
        rvalid_r <= 1'b1;
        rlast_r  <= (left_r == LW'(1));
      end else if (cmd.move) begin
        rvalid_r <= 1'b0;
      end
      if (cmd.load_single || cmd.move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // burst address and store select
  always_ff @(posedge clk) begin
    if (cmd.burst_start) begin
      addr_r    <= sel_rd[IW-1:0];
      sel_pub_r <= (opcode == mpss_pkg::OP_RD_PUB);
    end else if (cmd.issue) begin
      addr_r    <= addr_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) ctrl_mem_r[c_base[IW-1:0]] <= rx_byte;
    if (cmd.issue && !sel_pub_r) ctrl_q_r <= ctrl_mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (p_we) pub_mem_r[p_base[IW-1:0]] <= rx_byte;
    if (cmd.issue && sel_pub_r) pub_q_r <= pub_mem_r[addr_r];
  end

  // output register payload
  always_ff @(posedge clk) begin
    logic [EW-1:0] cav_e;
    logic [EW-1:0] pav_e;
    if (cmd.load_single) begin
      cav_e = EW'(ctrl_wr_nxt - ctrl_rd_nxt);
      pav_e = EW'(pub_wr_nxt - pub_rd_nxt);
    end else begin
      cav_e = EW'(ctrl_wr_r - ctrl_rd_r);
      pav_e = EW'(pub_wr_r - pub_rd_r);
    end
    if (cmd.load_single) begin
      data_r <= '0;
      rvld_r <= 1'b0;
      last_r <= 1'b1;
      drop_r <= drop_c;
      cav_r  <= cav_e[mpss_pkg::AVAIL_W-1:0];
      pav_r  <= pav_e[mpss_pkg::AVAIL_W-1:0];
      idle_r <= (route_nxt == mpss_pkg::ROUTE_PENDING);
    end else if (cmd.move) begin
      data_r <= sel_pub_r ? pub_q_r : ctrl_q_r;
      rvld_r <= 1'b1;
      last_r <= rlast_r;
      drop_r <= 1'b0;
      cav_r  <= cav_e[mpss_pkg::AVAIL_W-1:0];
      pav_r  <= pav_e[mpss_pkg::AVAIL_W-1:0];
      idle_r <= (route_r == mpss_pkg::ROUTE_PENDING);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = data_r;
  assign out_read_valid = rvld_r;
  assign out_last       = last_r;
  assign out_dropped    = drop_r;
  assign out_ctrl_avail = cav_r;
  assign out_pub_avail  = pav_r;
  assign out_idle       = idle_r;

endmodule

// ===== rtl/core/mqtt_packet_stream_splitter.sv =====
// Top level of the MQTT packet stream splitter.
// Instantiates mpss_ctrl and mpss_dp; uses mpss_pkg.
//
// Splits a received byte stream into MQTT packets by their fixed header and
// queues each packet's bytes, header included, into one of two linear stores
// of STORE_DEPTH bytes: PUBLISH packets (type nibble 3) to the publish store,
// all others to the control store. The remaining length uses the standard
// variable-length code (up to four bytes) and is counted down to the packet
// end. Opcode 0 pushes one byte and returns one beat (byte_dropped set if the
// target store was full; the parser still advances). Opcodes 1 and 2 read
// read_count bytes (1..MAX_READ) from the control or publish store, all or
// nothing: an out-of-range count or too few bytes returns a single beat with
// read_valid low and consumes nothing. Opcode 3 clears both stores and the
// parser. A store that drains empty rewinds to address 0 on its next write.
// Every beat carries the availabilities after the whole command. A push,
// restart or refused read returns a single beat; a read commits, then streams
// through the single read port of each store, a registered read, one byte per
// cycle while the output register is free, and the block takes no new command
// until its last byte is in the output register. The output register holds
// one beat; a new command is taken in the same cycle that beat leaves.
module mqtt_packet_stream_splitter #(
  parameter int STORE_DEPTH = 256,
  parameter int MAX_READ    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [14:8] read_count, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] read_data, [8] byte_dropped,
                                  // [17:9] ctrl_available, [26:18] pub_available,
                                  // [27] parser_idle, [31:28] zero
  output logic        out_tuser,  // [0] read_valid
  output logic        out_tlast   // last_of_run
);

  mpss_pkg::cmd_t cmd;
  mpss_pkg::sts_t sts;

  logic [7:0]                   read_data;
  logic                         dropped;
  logic                         idle;
  logic [mpss_pkg::AVAIL_W-1:0] ctrl_avail;
  logic [mpss_pkg::AVAIL_W-1:0] pub_avail;

  // command sequencing and input handshake
  mpss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .opcode    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, parser, read pipeline and output register
  mpss_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .opcode         (in_tuser),
    .rx_byte        (in_tdata[7:0]),
    .read_count     (in_tdata[14:8]),
    .out_tready     (out_tready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_tvalid),
    .out_read_data  (read_data),
    .out_read_valid (out_tuser),
    .out_last       (out_tlast),
    .out_dropped    (dropped),
    .out_ctrl_avail (ctrl_avail),
    .out_pub_avail  (pub_avail),
    .out_idle       (idle)
  );

  // pack result beat, lowest field first
  assign out_tdata = {4'b0000, idle, pub_avail, ctrl_avail, dropped, read_data};

endmodule
